### rtl/b64e_pkg.sv
// Shared types, constants and the base64 alphabet function for the stream encoder.
package b64e_pkg;

    // Most characters one request can produce: sextet, flush sextet, two pads
    localparam int MAX_CHARS = 4;
    localparam int IDX_W = 2;
    localparam int CHAR_W = 7;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // ASCII '=' used for padding
    localparam logic [CHAR_W-1:0] PAD_CODE = 7'd61;

    // Count of pending message bits
    typedef enum logic [1:0] {
        PH_NONE = 2'd0,
        PH_TWO  = 2'd1,
        PH_FOUR = 2'd2
    } phase_t;

    // Work for the back end: the characters of one request in output order
    typedef struct packed {
        logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
        logic [IDX_W-1:0]                 last_idx;
        logic                             final_req;
    } job_t;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
    function automatic logic [CHAR_W-1:0] b64e_char(input logic [5:0] sextet);
        logic [CHAR_W-1:0] s;
        logic [CHAR_W-1:0] code;
        s = {1'b0, sextet};
        if (sextet < 6'd26) begin
            code = 7'd65 + s;
        end else if (sextet < 6'd52) begin
            code = 7'd71 + s;
        end else if (sextet < 6'd62) begin
            code = s - 7'd4;
        end else if (sextet == 6'd62) begin
            code = 7'd43;
        end else begin
            code = 7'd47;
        end
        return code;
    endfunction

endpackage

### rtl/b64e_front.sv
// Front end: accepts message bytes, tracks pending bits and builds character jobs.
module b64e_front
    import b64e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    input  logic       queue_full,
    output logic       push,
    output job_t       push_job
);

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [3:0] leftover_reg;
    logic [3:0] leftover_next;
    job_t       job;

    assign push     = byte_valid && !queue_full;
    assign push_job = job;

    // Split the byte against pending bits; on a final byte that leaves bits over, add flush and pads
    always_comb
    begin
        job.chars     = {MAX_CHARS{PAD_CODE}};
        job.last_idx  = '0;
        job.final_req = final_byte;
        phase_next    = PH_NONE;
        leftover_next = '0;
        unique case (phase_reg)
            PH_TWO:
            begin
                job.chars[0] = b64e_char({leftover_reg[1:0], data_byte[7:4]});
                if (final_byte)
                begin
                    job.chars[1] = b64e_char({data_byte[3:0], 2'b00});
                    job.last_idx = 2'd2;
                end
                else
                begin
                    phase_next    = PH_FOUR;
                    leftover_next = data_byte[3:0];
                end
            end
            PH_FOUR:
            begin
                job.chars[0] = b64e_char({leftover_reg, data_byte[7:6]});
                job.chars[1] = b64e_char(data_byte[5:0]);
                job.last_idx = 2'd1;
            end
            default:
            begin
                // no pending bits (unused code behaves the same)
                job.chars[0] = b64e_char(data_byte[7:2]);
                if (final_byte)
                begin
                    job.chars[1] = b64e_char({data_byte[1:0], 4'b0000});
                    job.last_idx = 2'd3;
                end
                else
                begin
                    phase_next    = PH_TWO;
                    leftover_next = {2'b00, data_byte[1:0]};
                end
            end
        endcase
    end

    // Pending-bit state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_NONE;
            leftover_reg <= '0;
        end
        else if (push)
        begin
            phase_reg    <= phase_next;
            leftover_reg <= leftover_next;
        end
    end

endmodule

### rtl/b64e_queue.sv
// Short job queue between the front and back ends.
module b64e_queue
    import b64e_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output job_t head_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/b64e_back.sv
// Back end: walks the head job one character per cycle, while the output is not stalled, into the output register.
module b64e_back
    import b64e_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  job_t              head_job,
    output logic              pop,
    output logic              char_valid,
    input  logic              char_stall,
    output logic [CHAR_W-1:0] char_code,
    output logic              run_end,
    output logic              message_end
);

    logic [IDX_W-1:0]  idx_reg;
    logic              out_valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              run_end_reg;
    logic              msg_end_reg;
    logic              load;
    logic              is_last;

    assign load    = head_valid && (!out_valid_reg || !char_stall);
    assign is_last = (idx_reg == head_job.last_idx);
    assign pop     = load && is_last;

    assign char_valid  = out_valid_reg;
    assign char_code   = char_reg;
    assign run_end     = run_end_reg;
    assign message_end = msg_end_reg;

    // Character index within the head job, and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                idx_reg <= is_last ? '0 : idx_reg + 1'b1;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!char_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg    <= head_job.chars[idx_reg];
            run_end_reg <= is_last;
            msg_end_reg <= is_last && head_job.final_req;
        end
    end

endmodule

### rtl/base64_stream_encoder_unit.sv
// Top level of the streaming base64 encoder.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------
//  byte in  | byte_valid, byte_stall | data_byte[7:0], final_byte
//  char out | char_valid, char_stall | char_code[6:0], run_end, message_end
//
// The back end issues one character per cycle while char_stall is low; a byte
// yields one or two characters, or two to four on the final byte of a message.
// The output register is the limit: sustained rate is one character a cycle while char_stall is low.
// A byte's first character passes through a queue entry and then the output register before it is valid.
// Reset clears the pending bits, the queue pointers and count, and the output valid.
// Bytes keep flowing into the queue while the output is stalled, until it fills.
module base64_stream_encoder_unit
    import b64e_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  logic [7:0]        data_byte,
    input  logic              final_byte,
    output logic              char_valid,
    input  logic              char_stall,
    output logic [CHAR_W-1:0] char_code,
    output logic              run_end,
    output logic              message_end
);

    logic push;
    job_t push_job;
    logic pop;
    logic full;
    logic head_valid;
    job_t head_job;

    assign byte_stall = full;

    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .queue_full (full),
        .push       (push),
        .push_job   (push_job)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    b64e_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_job    (head_job),
        .pop         (pop),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_code   (char_code),
        .run_end     (run_end),
        .message_end (message_end)
    );

endmodule

### rtl/b64e_checker.sv
// Port-level checks for the base64 stream encoder, bound to the top level.
module b64e_checker
    import b64e_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              char_valid,
    input logic              char_stall,
    input logic [CHAR_W-1:0] char_code,
    input logic              run_end,
    input logic              message_end
);

    // End of message is always the end of a request's characters
    a_msg_end_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && message_end |-> run_end)
        else $error("message_end without run_end");

    // A pad that closes a request closes the message
    a_pad_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && (char_code == PAD_CODE) && run_end |-> message_end)
        else $error("padding ends a request but not the message");

    // Only alphabet characters or padding come out
    a_legal_code: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> ((char_code >= 7'd65) && (char_code <= 7'd90)) ||
                       ((char_code >= 7'd97) && (char_code <= 7'd122)) ||
                       ((char_code >= 7'd48) && (char_code <= 7'd57)) ||
                       (char_code == 7'd43) || (char_code == 7'd47) ||
                       (char_code == PAD_CODE))
        else $error("illegal character code");

    // Stalled output holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_stall |=> char_valid && $stable(char_code) &&
                                     $stable(run_end) && $stable(message_end))
        else $error("output changed while stalled");

endmodule

bind base64_stream_encoder_unit b64e_checker u_b64e_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .char_code   (char_code),
    .run_end     (run_end),
    .message_end (message_end)
);
